// ===== rtl/dcd_pkg.sv =====
// Shared sizes, reset value and controller state codes for divisor_chain_distance.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
package dcd_pkg;
   localparam int VALUE_BITS  = 24;
   localparam int ROOT_BOUND  = 4096;
   localparam int PRIME_SLOTS = 1024;
   localparam int CHAIN_DEPTH = 25;

   localparam int FIELD_BITS = 24;
   localparam int DIST_BITS  = 6;

   localparam int ROOT_BITS  = $clog2(ROOT_BOUND + 1);
   localparam int MULT_BITS  = ROOT_BITS + 1;
   localparam int PRIME_BITS = $clog2(ROOT_BOUND);
   localparam int SQRT_BITS  = (VALUE_BITS + 1) / 2;
   localparam int SQK_BITS   = (SQRT_BITS > 1) ? $clog2(SQRT_BITS) : 1;
   localparam int PADDR_BITS = $clog2(PRIME_SLOTS);
   localparam int PCNT_BITS  = $clog2(PRIME_SLOTS + 1);
   localparam int CIDX_BITS  = $clog2(CHAIN_DEPTH);
   localparam int LEN_BITS   = $clog2(CHAIN_DEPTH + 1);
   localparam int DCNT_BITS  = $clog2(VALUE_BITS + 1);

   localparam logic [VALUE_BITS-1:0] LIMIT_RESET = VALUE_BITS'(24'hFFFFFF);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_ROOT   = 14'b00000000000010,
      ST_CLEAR  = 14'b00000000000100,
      ST_SREAD  = 14'b00000000001000,
      ST_SCHECK = 14'b00000000010000,
      ST_SMARK  = 14'b00000000100000,
      ST_RANGE  = 14'b00000001000000,
      ST_STEP   = 14'b00000010000000,
      ST_PREAD  = 14'b00000100000000,
      ST_PCMP   = 14'b00001000000000,
      ST_DIV    = 14'b00010000000000,
      ST_DIVEND = 14'b00100000000000,
      ST_TAIL   = 14'b01000000000000,
      ST_DONE   = 14'b10000000000000
   } state_type;
endpackage

// ===== rtl/dcd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/divisor_chain_distance.sv =====
// Divisor tree distance engine: sieve, trial-division chain builder, tail matcher.
// Depends on dcd_pkg and dcd_ram.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/req_stall| req_value_a, req_value_b
//  rsp     | out | rsp_valid/rsp_stall| rsp_tree_distance, rsp_out_of_range
//  csr     | in  | csr_valid/csr_ready| csr_value_limit (always ready)
//
//  One query at a time. Each trial division runs on the shared restoring
//  divider (prime read, square, compare, shift steps), so a query's time
//  grows with the primes tried over both chains; a prime value near the limit
//  tries ~560 primes. Flagged beats skip the chain building. The first beat
//  after reset or a limit write first rebuilds the table: a bitwise root
//  search over SQRT_BITS bits, a clearing pass over the ROOT_BOUND+1
//  composite marks, then the sieve. Reset is synchronous; the result
//  register lets a new beat in while the old result waits under rsp_stall.
module divisor_chain_distance (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [dcd_pkg::FIELD_BITS-1:0]   req_value_a,
   input  logic [dcd_pkg::FIELD_BITS-1:0]   req_value_b,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [dcd_pkg::DIST_BITS-1:0]    rsp_tree_distance,
   output logic                             rsp_out_of_range,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dcd_pkg::FIELD_BITS-1:0]   csr_value_limit
);
   import dcd_pkg::*;

   // control state
   state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]  limit_ff, limit_in;
   logic                   tbl_ready_ff, tbl_ready_in;
   logic [PCNT_BITS-1:0]   pcount_ff, pcount_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [ROOT_BITS-1:0]   root_ff, root_in;
   logic [SQRT_BITS-1:0]   sq_ff, sq_in;
   logic [SQK_BITS-1:0]    kb_ff, kb_in;
   logic [ROOT_BITS-1:0]   clr_ff, clr_in;
   logic [MULT_BITS-1:0]   p_ff, p_in;
   logic [MULT_BITS-1:0]   m_ff, m_in;
   logic [VALUE_BITS-1:0]  a_ff, a_in, b_ff, b_in, v_ff, v_in;
   logic [LEN_BITS-1:0]    len_ff, len_in, la_ff, la_in, lb_ff, lb_in;
   logic [LEN_BITS-1:0]    common_ff, common_in;
   logic                   side_ff, side_in;
   logic [PCNT_BITS-1:0]   pidx_ff, pidx_in;
   logic [PRIME_BITS-1:0]  x_ff, x_in;
   logic [2*PRIME_BITS-1:0] xsq_ff, xsq_in;
   logic [PRIME_BITS-1:0]  rem_ff, rem_in;
   logic [VALUE_BITS-1:0]  quo_ff, quo_in;
   logic [DCNT_BITS-1:0]   dcnt_ff, dcnt_in;
   logic [DIST_BITS-1:0]   dist_ff, dist_in, rsp_dist_ff, rsp_dist_in;
   logic                   flag_ff, flag_in, rsp_flag_ff, rsp_flag_in;

   // chain stores
   logic [VALUE_BITS-1:0]  chain_a_ff [CHAIN_DEPTH];
   logic [VALUE_BITS-1:0]  chain_b_ff [CHAIN_DEPTH];
   logic                   cw_en, cw_side;
   logic [CIDX_BITS-1:0]   cw_idx;
   logic [VALUE_BITS-1:0]  cw_data;

   // memories
   logic                   mk_we, mk_wdata, mk_rdata;
   logic [ROOT_BITS-1:0]   mk_waddr;
   logic                   pt_we;
   logic [PRIME_BITS-1:0]  pt_rdata;

   // combinational helpers
   logic [SQRT_BITS-1:0]   cand;
   logic [2*SQRT_BITS-1:0] cand_sq;
   logic [31:0]            sq_cap;
   logic [PRIME_BITS:0]    trial, diff;
   logic                   ge;
   logic [LEN_BITS-1:0]    ia, ib;
   logic                   tail_eq;
   logic [LEN_BITS:0]      dsum;
   logic                   accept, load_rsp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   dcd_ram #(.WIDTH(1), .DEPTH(ROOT_BOUND + 1)) u_marks (
      .clock   (clock),
      .wr_en   (mk_we),
      .wr_addr (mk_waddr),
      .wr_data (mk_wdata),
      .rd_addr (p_ff[ROOT_BITS-1:0]),
      .rd_data (mk_rdata)
   );

   dcd_ram #(.WIDTH(PRIME_BITS), .DEPTH(PRIME_SLOTS)) u_primes (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pcount_ff[PADDR_BITS-1:0]),
      .wr_data (p_ff[PRIME_BITS-1:0]),
      .rd_addr (pidx_ff[PADDR_BITS-1:0]),
      .rd_data (pt_rdata)
   );

   // root search candidate and its square
   assign cand    = sq_ff | (SQRT_BITS'(1) << kb_ff);
   assign cand_sq = (2*SQRT_BITS)'(cand) * (2*SQRT_BITS)'(cand);

   // one restoring divide step
   assign trial = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign ge    = trial >= {1'b0, x_ff};
   assign diff  = trial - {1'b0, x_ff};

   // tail compare, newest index from the root end
   assign ia      = la_ff - common_ff - LEN_BITS'(1);
   assign ib      = lb_ff - common_ff - LEN_BITS'(1);
   assign tail_eq = (common_ff < la_ff) && (common_ff < lb_ff) &&
                    (chain_a_ff[ia[CIDX_BITS-1:0]] == chain_b_ff[ib[CIDX_BITS-1:0]]);
   assign dsum    = (LEN_BITS+1)'(la_ff - common_ff) + (LEN_BITS+1)'(lb_ff - common_ff);

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      tbl_ready_in = tbl_ready_ff;
      pcount_in    = pcount_ff;
      root_in      = root_ff;
      sq_in        = sq_ff;
      kb_in        = kb_ff;
      clr_in       = clr_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      v_in         = v_ff;
      len_in       = len_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      common_in    = common_ff;
      side_in      = side_ff;
      pidx_in      = pidx_ff;
      x_in         = x_ff;
      xsq_in       = xsq_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      dist_in      = dist_ff;
      flag_in      = flag_ff;
      sq_cap       = 32'(sq_ff);
      mk_we        = 1'b0;
      mk_waddr     = clr_ff;
      mk_wdata     = 1'b0;
      pt_we        = 1'b0;
      cw_en        = 1'b0;
      cw_side      = side_ff;
      cw_idx       = len_ff[CIDX_BITS-1:0];
      cw_data      = v_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               a_in = VALUE_BITS'(req_value_a);
               b_in = VALUE_BITS'(req_value_b);
               if (tbl_ready_ff) begin
                  state_in = ST_RANGE;
               end else begin
                  sq_in    = '0;
                  kb_in    = SQK_BITS'(SQRT_BITS - 1);
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            if (64'(cand_sq) <= 64'(limit_ff)) begin
               sq_in = cand;
            end
            kb_in = kb_ff - SQK_BITS'(1);
            if (kb_ff == '0) begin
               sq_cap   = 32'(sq_in);
               root_in  = (sq_cap > 32'(ROOT_BOUND)) ? ROOT_BITS'(ROOT_BOUND)
                                                     : ROOT_BITS'(sq_cap);
               clr_in   = '0;
               state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            mk_we    = 1'b1;
            mk_waddr = clr_ff;
            mk_wdata = 1'b0;
            clr_in   = clr_ff + ROOT_BITS'(1);
            if (clr_ff == ROOT_BITS'(ROOT_BOUND)) begin
               p_in      = MULT_BITS'(2);
               pcount_in = '0;
               state_in  = ST_SREAD;
            end
         end
         ST_SREAD: begin
            if (p_ff > MULT_BITS'(root_ff)) begin
               tbl_ready_in = 1'b1;
               state_in     = ST_RANGE;
            end else begin
               state_in = ST_SCHECK;
            end
         end
         ST_SCHECK: begin
            if (!mk_rdata) begin
               if (pcount_ff < PCNT_BITS'(PRIME_SLOTS)) begin
                  pt_we     = 1'b1;
                  pcount_in = pcount_ff + PCNT_BITS'(1);
               end
               m_in     = p_ff + p_ff;
               state_in = ST_SMARK;
            end else begin
               p_in     = p_ff + MULT_BITS'(1);
               state_in = ST_SREAD;
            end
         end
         ST_SMARK: begin
            if (m_ff > MULT_BITS'(root_ff)) begin
               p_in     = p_ff + MULT_BITS'(1);
               state_in = ST_SREAD;
            end else begin
               mk_we    = 1'b1;
               mk_waddr = m_ff[ROOT_BITS-1:0];
               mk_wdata = 1'b1;
               m_in     = m_ff + p_ff;
            end
         end
         ST_RANGE: begin
            if (a_ff == '0 || b_ff == '0 || a_ff > limit_ff || b_ff > limit_ff) begin
               dist_in  = '0;
               flag_in  = 1'b1;
               state_in = ST_DONE;
            end else begin
               cw_en    = 1'b1;
               cw_side  = 1'b0;
               cw_idx   = '0;
               cw_data  = a_ff;
               side_in  = 1'b0;
               v_in     = a_ff;
               len_in   = LEN_BITS'(1);
               pidx_in  = '0;
               flag_in  = 1'b0;
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (v_ff == VALUE_BITS'(1) || len_ff == LEN_BITS'(CHAIN_DEPTH)) begin
               if (!side_ff) begin
                  la_in   = len_ff;
                  cw_en   = 1'b1;
                  cw_side = 1'b1;
                  cw_idx  = '0;
                  cw_data = b_ff;
                  side_in = 1'b1;
                  v_in    = b_ff;
                  len_in  = LEN_BITS'(1);
                  pidx_in = '0;
               end else begin
                  lb_in     = len_ff;
                  common_in = '0;
                  state_in  = ST_TAIL;
               end
            end else if (pidx_ff >= pcount_ff) begin
               // table exhausted: value is prime, parent is the root
               cw_en   = 1'b1;
               cw_data = VALUE_BITS'(1);
               v_in    = VALUE_BITS'(1);
               len_in  = len_ff + LEN_BITS'(1);
            end else begin
               state_in = ST_PREAD;
            end
         end
         ST_PREAD: begin
            x_in     = pt_rdata;
            xsq_in   = (2*PRIME_BITS)'(pt_rdata) * (2*PRIME_BITS)'(pt_rdata);
            state_in = ST_PCMP;
         end
         ST_PCMP: begin
            if (64'(xsq_ff) > 64'(v_ff)) begin
               cw_en    = 1'b1;
               cw_data  = VALUE_BITS'(1);
               v_in     = VALUE_BITS'(1);
               len_in   = len_ff + LEN_BITS'(1);
               state_in = ST_STEP;
            end else begin
               rem_in   = '0;
               quo_in   = v_ff;
               dcnt_in  = DCNT_BITS'(VALUE_BITS);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = ge ? diff[PRIME_BITS-1:0] : trial[PRIME_BITS-1:0];
            quo_in  = {quo_ff[VALUE_BITS-2:0], ge};
            dcnt_in = dcnt_ff - DCNT_BITS'(1);
            if (dcnt_ff == DCNT_BITS'(1)) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            // smallest factors never decrease along a chain, so the prime
            // index carries over to the parent
            if (rem_ff == '0) begin
               cw_en   = 1'b1;
               cw_data = quo_ff;
               v_in    = quo_ff;
               len_in  = len_ff + LEN_BITS'(1);
            end else begin
               pidx_in = pidx_ff + PCNT_BITS'(1);
            end
            state_in = ST_STEP;
         end
         ST_TAIL: begin
            if (tail_eq) begin
               common_in = common_ff + LEN_BITS'(1);
            end else begin
               dist_in  = DIST_BITS'(dsum);
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid && csr_ready) begin
         limit_in     = VALUE_BITS'(csr_value_limit);
         tbl_ready_in = 1'b0;
      end
   end

   always_comb begin
      rsp_dist_in  = rsp_dist_ff;
      rsp_flag_in  = rsp_flag_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_dist_in  = dist_ff;
         rsp_flag_in  = flag_ff;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         tbl_ready_ff <= 1'b0;
         pcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         tbl_ready_ff <= tbl_ready_in;
         pcount_ff    <= pcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_ff     <= root_in;
      sq_ff       <= sq_in;
      kb_ff       <= kb_in;
      clr_ff      <= clr_in;
      p_ff        <= p_in;
      m_ff        <= m_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      v_ff        <= v_in;
      len_ff      <= len_in;
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      common_ff   <= common_in;
      side_ff     <= side_in;
      pidx_ff     <= pidx_in;
      x_ff        <= x_in;
      xsq_ff      <= xsq_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      dcnt_ff     <= dcnt_in;
      dist_ff     <= dist_in;
      flag_ff     <= flag_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_flag_ff <= rsp_flag_in;
      if (cw_en) begin
         if (cw_side) begin
            chain_b_ff[cw_idx] <= cw_data;
         end else begin
            chain_a_ff[cw_idx] <= cw_data;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tree_distance = rsp_dist_ff;
   assign rsp_out_of_range  = rsp_flag_ff;

   a_pcount_bound: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= PCNT_BITS'(PRIME_SLOTS))
      else $error("prime count beyond table size");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted beat did not start work");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_flag_ff) |-> (rsp_dist_ff == '0))
      else $error("flagged result with nonzero distance");

   a_tail_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL) |-> (common_ff <= la_ff && common_ff <= lb_ff))
      else $error("common tail longer than a chain");
endmodule
